@@ rtl/utp_pkg.sv @@
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, codes and helpers of the UTF-8 text paginator.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // queue operation codes
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_ERR  = 2'd1;
    localparam logic [1:0] OP_EOF  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAGE     = 2'd0;
    localparam logic [1:0] KIND_ERROR    = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_DONE_ERR = 2'd3;

    // register indexes
    localparam logic [2:0] REG_NARROW = 3'd0;
    localparam logic [2:0] REG_WIDE   = 3'd1;
    localparam logic [2:0] REG_LINE_W = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    localparam logic [7:0]  BYTE_LF    = 8'h0A;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic        flag;   // OP_CHAR: multibyte; OP_EOF: error seen
        logic        lf;
        logic [31:0] value;  // byte offset or byte total
    } qent_t;

    typedef struct packed {
        logic [7:0]  narrow_width;
        logic [7:0]  wide_width;
        logic [11:0] line_width;
        logic [7:0]  line_pitch;
        logic [11:0] page_height;
    } cfg_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

    function automatic logic [2:0] trail_count(input logic [7:0] b);
        if (!b[5])
            trail_count = 3'd1;
        else if (!b[4])
            trail_count = 3'd2;
        else if (!b[3])
            trail_count = 3'd3;
        else if (!b[2])
            trail_count = 3'd4;
        else
            trail_count = 3'd5;
    endfunction

endpackage

@@ rtl/utf8_text_paginator_top.sv @@
// ----------------------------------------------------------------------------
// utf8_text_paginator_top
// Splits a UTF-8 byte stream into display pages.
//
// Input stream (s_*): one item per byte; s_tuser is the command (0 text byte,
// 1 end of file), s_tdata the byte. Output stream (m_*): page starts,
// encoding errors and end-of-file summaries; m_tuser is the kind.
// Configuration channel (cfg_*): register index and data, always ready;
// write only while the block is idle.
// Throughput: one item per cycle while the queue is not full. The classifier
// updates its counters as the item is accepted; the layout engine takes one
// queue entry per cycle unless a result stalls, its pen update being a 13-bit
// add and compare followed by the page check. A result passes from its input
// item through the queue into the result register, which drives m_tvalid.
// When a result waits with m_tready low the result register holds, the
// four-entry queue fills and s_tready drops once it is full.
// Reset: all counters and the pen cleared, registers take their defaults
// (narrow 6, wide 12, line width 296, pitch 14, height 128).
// ----------------------------------------------------------------------------
module utf8_text_paginator_top
    import utp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] page_number, [63:32] byte_offset
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_full, q_empty, q_push, q_pop, s_accept;
    qent_t q_in, q_head;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.narrow_width <= 8'd6;
            cfg_reg.wide_width   <= 8'd12;
            cfg_reg.line_width   <= 12'd296;
            cfg_reg.line_pitch   <= 8'd14;
            cfg_reg.page_height  <= 12'd128;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NARROW: cfg_reg.narrow_width <= cfg_data[7:0];
                REG_WIDE:   cfg_reg.wide_width   <= cfg_data[7:0];
                REG_LINE_W: cfg_reg.line_width   <= cfg_data;
                REG_PITCH:  cfg_reg.line_pitch   <= cfg_data[7:0];
                REG_HEIGHT: cfg_reg.page_height  <= cfg_data;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    utp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .cmd        (s_tuser),
        .byte_value (s_tdata),
        .push       (q_push),
        .push_ent   (q_in)
    );

    utp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_in),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    utp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .empty      (q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_page   (m_tdata[31:0]),
        .out_offset (m_tdata[63:32])
    );

endmodule

@@ rtl/utp_front.sv @@
// ----------------------------------------------------------------------------
// utp_front
// Byte classifier: counts bytes, skips continuation bytes, flags stray
// continuation bytes and forwards characters, errors and end of file.
// ----------------------------------------------------------------------------
module utp_front
    import utp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        cmd,
    input  logic [7:0]  byte_value,
    output logic        push,
    output qent_t       push_ent
);

    logic [31:0] byte_cnt_reg, byte_cnt_next;
    logic [2:0]  skip_reg, skip_next;
    logic        err_reg, err_next;

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        skip_next     = skip_reg;
        err_next      = err_reg;
        push          = 1'b0;
        push_ent.op   = OP_CHAR;
        push_ent.flag = 1'b0;
        push_ent.lf   = 1'b0;
        push_ent.value = byte_cnt_reg;
        if (accept)
        begin
            if (cmd)
            begin
                push          = 1'b1;
                push_ent.op   = OP_EOF;
                push_ent.flag = err_reg;
                byte_cnt_next = '0;
                skip_next     = '0;
                err_next      = 1'b0;
            end
            else
            begin
                byte_cnt_next = sat_inc(byte_cnt_reg);
                if (err_reg)
                begin
                    skip_next = skip_reg;
                end
                else if (skip_reg != 3'd0)
                begin
                    skip_next = skip_reg - 3'd1;
                end
                else if (byte_value[7] && !byte_value[6])
                begin
                    err_next    = 1'b1;
                    push        = 1'b1;
                    push_ent.op = OP_ERR;
                end
                else
                begin
                    push          = 1'b1;
                    push_ent.flag = byte_value[7];
                    push_ent.lf   = (byte_value == BYTE_LF);
                    skip_next     = byte_value[7] ? trail_count(byte_value) : 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            skip_reg     <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            skip_reg     <= skip_next;
            err_reg      <= err_next;
        end
    end

endmodule

@@ rtl/utp_queue.sv @@
// ----------------------------------------------------------------------------
// utp_queue
// Small FIFO between the classifier and the layout engine.
// ----------------------------------------------------------------------------
module utp_queue
    import utp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_ent,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output qent_t head
);

    qent_t             mem [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count missed a write");
`endif

endmodule

@@ rtl/utp_back.sv @@
// ----------------------------------------------------------------------------
// utp_back
// Layout engine: pen position, line wrap, page breaks and the result register.
// ----------------------------------------------------------------------------
module utp_back
    import utp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        empty,
    input  qent_t       head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [31:0] out_page,
    output logic [31:0] out_offset
);

    logic [11:0] pen_x_reg, pen_x_next;
    logic [11:0] pen_y_reg, pen_y_next;
    logic [31:0] page_cnt_reg, page_cnt_next;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg, kind_next;
    logic [31:0] out_page_reg, page_out_next;
    logic [31:0] out_offset_reg;
    logic        res_next;

    logic [7:0]  adv;
    logic [12:0] x_sum;
    logic        wrap;
    logic        step;
    logic [12:0] y_one;
    logic [13:0] y_chk;
    logic        brk;

    assign pop = !empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        adv   = head.lf ? 8'd0 : (head.flag ? cfg.wide_width : cfg.narrow_width);
        x_sum = {1'b0, pen_x_reg} + {5'd0, adv};
        wrap  = !head.lf && (x_sum >= {1'b0, cfg.line_width});
        step  = head.lf || wrap;
        y_one = {1'b0, pen_y_reg} + (step ? {5'd0, cfg.line_pitch} : 13'd0);
        y_chk = {1'b0, y_one} + {6'd0, cfg.line_pitch};
        brk   = (y_chk >= {2'd0, cfg.page_height});
    end

    always_comb
    begin
        pen_x_next    = pen_x_reg;
        pen_y_next    = pen_y_reg;
        page_cnt_next = page_cnt_reg;
        res_next      = 1'b0;
        kind_next     = KIND_PAGE;
        page_out_next = page_cnt_reg;
        case (head.op)
            OP_EOF:
            begin
                res_next      = 1'b1;
                kind_next     = head.flag ? KIND_DONE_ERR : KIND_DONE;
                page_out_next = sat_inc(page_cnt_reg);
                pen_x_next    = '0;
                pen_y_next    = '0;
                page_cnt_next = '0;
            end
            OP_ERR:
            begin
                res_next  = 1'b1;
                kind_next = KIND_ERROR;
            end
            OP_CHAR:
            begin
                if (brk)
                begin
                    page_cnt_next = sat_inc(page_cnt_reg);
                    page_out_next = page_cnt_next;
                    res_next      = 1'b1;
                    pen_x_next    = {4'd0, adv};
                    pen_y_next    = '0;
                end
                else
                begin
                    pen_y_next = y_one[11:0];
                    if (head.lf)
                        pen_x_next = '0;
                    else if (wrap)
                        pen_x_next = {4'd0, adv};
                    else
                        pen_x_next = x_sum[11:0];
                end
            end
            default:
            begin
                res_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            page_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pen_x_reg     <= pen_x_next;
                pen_y_reg     <= pen_y_next;
                page_cnt_reg  <= page_cnt_next;
                out_valid_reg <= res_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_next)
        begin
            out_kind_reg   <= kind_next;
            out_page_reg   <= page_out_next;
            out_offset_reg <= head.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_page   = out_page_reg;
    assign out_offset = out_offset_reg;

`ifndef NO_ASSERTIONS
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == OP_EOF) |=>
            (page_cnt_reg == '0 && pen_x_reg == '0 && pen_y_reg == '0))
        else $error("end of file left layout state behind");
    a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == OP_EOF) |=>
            (out_valid_reg && (out_kind_reg == KIND_DONE || out_kind_reg == KIND_DONE_ERR)))
        else $error("end of file gave no summary");
    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("queue read while result stalled");
`endif

endmodule
